### rtl/core/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types, beat layout and microcode ROM for the frustum box cull block.
// ----------------------------------------------------------------------------
package fbc_pkg;

    // opcode carried on s_axis_tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam int PLANE_COUNT  = 6;
    localparam int ORTHO_PLANES = 4;
    localparam int PLANE_W      = 3;
    localparam int COEF_W       = 32;
    localparam int ROW_W        = 4 * COEF_W;

    // input tdata layout, lowest bit first
    localparam int SLOT_LSB  = 0;
    localparam int A_LSB     = 3;
    localparam int B_LSB     = 35;
    localparam int C_LSB     = 67;
    localparam int D_LSB     = 99;
    localparam int P_LSB     = 131;
    localparam int Q_LSB     = 147;
    localparam int LOW_LSB   = 163;
    localparam int HIGH_LSB  = 171;
    localparam int S_TDATA_W = 184;
    localparam int M_TDATA_W = 8;

    localparam int UPC_W = 3;

    // one microcode word: what the datapath does in a step
    typedef struct packed {
        logic               mul_en;    // fetch plane row, form the three products
        logic               acc_en;    // sum products of previous step, test sign
        logic [PLANE_W-1:0] plane;     // plane fetched by mul_en
        logic               ortho_br;  // branch to jump_to when ortho mode set
        logic [UPC_W-1:0]   jump_to;
        logic               last;      // final step, result ready
    } t_uword;

    localparam logic [UPC_W-1:0] UPC_DRAIN = 3'd6;

    function automatic t_uword urom(input logic [UPC_W-1:0] pc);
        t_uword w;
        w = '0;
        unique case (pc)
            3'd0: begin
                w.mul_en = 1'b1; w.plane = 3'd0;
            end
            3'd1: begin
                w.mul_en = 1'b1; w.acc_en = 1'b1; w.plane = 3'd1;
            end
            3'd2: begin
                w.mul_en = 1'b1; w.acc_en = 1'b1; w.plane = 3'd2;
            end
            3'd3: begin
                w.mul_en = 1'b1; w.acc_en = 1'b1; w.plane = 3'd3;
                w.ortho_br = 1'b1; w.jump_to = UPC_DRAIN;
            end
            3'd4: begin
                w.mul_en = 1'b1; w.acc_en = 1'b1; w.plane = 3'd4;
            end
            3'd5: begin
                w.mul_en = 1'b1; w.acc_en = 1'b1; w.plane = 3'd5;
            end
            3'd6: begin
                w.acc_en = 1'b1; w.last = 1'b1;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

### rtl/core/frustum_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_box_cull
// View-frustum test of axis-aligned column boxes against six stored planes.
// ----------------------------------------------------------------------------
// A load beat (tuser = 0) writes one plane's a, b, c, d into the plane store
// and gives no result; slots six and seven are dropped. A test beat
// (tuser = 1) builds the box corners from the column and height range and
// returns one beat with visible = 0 when some active plane has all eight
// corners strictly negative. A microcoded sequencer steps one plane per
// cycle through three shared 32-bit multipliers, with the sum and sign test
// one step behind; a test beat holds off the input until after its last
// step, and ortho mode skips the steps for planes 4 and 5. The result
// sits in an output register, so the next beat is taken while it waits; the
// last step only stalls if the previous result has still not been taken.
// Unloaded planes read as zero and therefore never cull. ortho_mode may only
// be written while the block is idle.
// ----------------------------------------------------------------------------
module frustum_box_cull #(
    parameter int COLUMN_SIZE = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data,   // ortho_mode
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] plane_slot, [34:3] coef_a, [66:35] coef_b, [98:67] coef_c,
    // [130:99] coef_offset, [146:131] column_p, [162:147] column_q,
    // [170:163] low_y, [178:171] high_y, [183:179] zero
    input  logic [fbc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tuser,    // opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fbc_pkg::M_TDATA_W-1:0]   m_axis_tdata     // [0] visible, [7:1] zero
);

    logic            r_ortho;
    logic            r_out_valid;
    logic            r_out_vis;
    logic            busy;
    logic            beat_in;
    logic            load_beat, test_beat;
    logic            visible;
    fbc_pkg::t_uword uw;

    // config register; write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ortho <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_ortho <= i_cfg_wr_data;
        end
    end

    assign s_axis_tready = !busy;
    assign beat_in       = s_axis_tvalid && s_axis_tready;
    assign load_beat     = beat_in && (s_axis_tuser == fbc_pkg::OP_LOAD);
    assign test_beat     = beat_in && (s_axis_tuser == fbc_pkg::OP_TEST);

    fbc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (test_beat),
        .i_ortho    (r_ortho),
        .i_out_full (r_out_valid && !m_axis_tready),
        .o_busy     (busy),
        .o_uw       (uw)
    );

    fbc_datapath #(
        .COLUMN_SIZE (COLUMN_SIZE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load_beat),
        .i_test     (test_beat),
        .i_slot     (s_axis_tdata[fbc_pkg::SLOT_LSB +: fbc_pkg::PLANE_W]),
        .i_row      (s_axis_tdata[fbc_pkg::A_LSB +: fbc_pkg::ROW_W]),
        .i_column_p (s_axis_tdata[fbc_pkg::P_LSB +: 16]),
        .i_column_q (s_axis_tdata[fbc_pkg::Q_LSB +: 16]),
        .i_low_y    (s_axis_tdata[fbc_pkg::LOW_LSB +: 8]),
        .i_high_y   (s_axis_tdata[fbc_pkg::HIGH_LSB +: 8]),
        .i_uw       (uw),
        .o_visible  (visible)
    );

    // output register; the last step only advances when it is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.last) begin
            r_out_vis <= visible;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(fbc_pkg::M_TDATA_W-1){1'b0}}, r_out_vis};

endmodule

### rtl/core/fbc_seq.sv
// ----------------------------------------------------------------------------
// fbc_seq
// Microcode step counter; one control word per cycle, last step can stall.
// ----------------------------------------------------------------------------
module fbc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_ortho,
    input  logic            i_out_full,
    output logic            o_busy,
    output fbc_pkg::t_uword o_uw
);

    logic [fbc_pkg::UPC_W-1:0] r_pc, n_pc;
    logic                      r_busy, n_busy;
    fbc_pkg::t_uword           rom_w;
    logic                      adv;

    assign rom_w  = fbc_pkg::urom(r_pc);
    // last step waits while the result register is still full
    assign adv    = r_busy && !(rom_w.last && i_out_full);
    assign o_uw   = adv ? rom_w : '0;
    assign o_busy = r_busy;

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_start) begin
            n_pc   = '0;
            n_busy = 1'b1;
        end else if (adv) begin
            if (rom_w.last) begin
                n_busy = 1'b0;
            end else if (rom_w.ortho_br && i_ortho) begin
                n_pc = rom_w.jump_to;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

endmodule

### rtl/core/fbc_datapath.sv
// ----------------------------------------------------------------------------
// fbc_datapath
// Plane store, box corners, three plane multipliers and the sign test.
// ----------------------------------------------------------------------------
module fbc_datapath #(
    parameter int COLUMN_SIZE = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic                               i_test,
    input  logic [fbc_pkg::PLANE_W-1:0]        i_slot,
    input  logic [fbc_pkg::ROW_W-1:0]          i_row,
    input  logic signed [15:0]                 i_column_p,
    input  logic signed [15:0]                 i_column_q,
    input  logic [7:0]                         i_low_y,
    input  logic [7:0]                         i_high_y,
    input  fbc_pkg::t_uword                    i_uw,
    output logic                               o_visible
);

    localparam int CW = 17 + $clog2(COLUMN_SIZE + 1);   // corner width
    localparam int PW = fbc_pkg::COEF_W + CW;            // x/z product width
    localparam int SW = PW + 2;                           // sum width
    localparam logic signed [CW-1:0] CS = CW'(COLUMN_SIZE);

    // plane store: one row of a,b,c,d per plane, unwritten rows read as zero
    logic [fbc_pkg::ROW_W-1:0] r_rows [fbc_pkg::PLANE_COUNT];
    logic [fbc_pkg::PLANE_COUNT-1:0] r_row_vld;

    logic signed [CW-1:0] r_x0, r_x1, r_z0, r_z1;
    logic [7:0]           r_ymin, r_ymax;
    logic signed [CW-1:0] ps, qs;

    logic [fbc_pkg::ROW_W-1:0] row;
    logic signed [31:0]        ca, cb, cc, cd;
    logic signed [CW-1:0]      xs, zs;
    logic signed [8:0]         ys;

    logic signed [PW-1:0] r_pa, r_pc;
    logic signed [40:0]   r_pb;
    logic signed [31:0]   r_d;
    logic signed [SW-1:0] sum;
    logic                 reject;
    logic                 r_cull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_load && i_slot < fbc_pkg::PLANE_W'(fbc_pkg::PLANE_COUNT)) begin
            r_row_vld[i_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_slot < fbc_pkg::PLANE_W'(fbc_pkg::PLANE_COUNT)) begin
            r_rows[i_slot] <= i_row;
        end
    end

    assign ps = CW'(i_column_p) * CS;
    assign qs = CW'(i_column_q) * CS;

    always_ff @(posedge i_clk) begin
        if (i_test) begin
            r_x0   <= ps - CW'(1);
            r_x1   <= ps + CS;
            r_z0   <= qs - CW'(1);
            r_z1   <= qs + CS;
            r_ymin <= (i_low_y < i_high_y) ? i_low_y : i_high_y;
            r_ymax <= (i_low_y < i_high_y) ? i_high_y : i_low_y;
        end
    end

    // nearest-to-positive corner: if it is negative, all eight are
    assign row = (i_uw.plane < fbc_pkg::PLANE_W'(fbc_pkg::PLANE_COUNT)
                  && r_row_vld[i_uw.plane]) ? r_rows[i_uw.plane] : '0;
    assign ca = row[31:0];
    assign cb = row[63:32];
    assign cc = row[95:64];
    assign cd = row[127:96];
    assign xs = ca[31] ? r_x0 : r_x1;
    assign zs = cc[31] ? r_z0 : r_z1;
    assign ys = cb[31] ? $signed({1'b0, r_ymin}) : $signed({1'b0, r_ymax});

    always_ff @(posedge i_clk) begin
        if (i_uw.mul_en) begin
            r_pa <= ca * xs;
            r_pb <= cb * ys;
            r_pc <= cc * zs;
            r_d  <= cd;
        end
    end

    assign sum    = SW'(r_pa) + SW'(r_pb) + SW'(r_pc) + SW'(r_d);
    assign reject = sum[SW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cull <= 1'b0;
        end else if (i_test) begin
            r_cull <= 1'b0;
        end else if (i_uw.acc_en && reject) begin
            r_cull <= 1'b1;
        end
    end

    assign o_visible = !(r_cull || (i_uw.acc_en && reject));

endmodule

### rtl/core/fbc_checker.sv
// ----------------------------------------------------------------------------
// fbc_checker
// Port-level checks on the frustum box cull block, bound to the top level.
// ----------------------------------------------------------------------------
module fbc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [fbc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // a test beat occupies the sequencer
    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == fbc_pkg::OP_TEST)
        |=> !s_axis_tready)
        else $error("input ready straight after a test beat");

    // a load completes in its own cycle
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == fbc_pkg::OP_LOAD)
        |=> s_axis_tready)
        else $error("input stalled after a load beat");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[fbc_pkg::M_TDATA_W-1:1] == '0))
        else $error("result padding not zero");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat straight after reset");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
